// ----- hdl/lfu_pkg.sv -----
// Shared constants and codes for the LFU cache store.
package lfu_pkg;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_KEY_BITS   = 16;
  localparam int DEF_VALUE_BITS = 32;

  // Width of the per-entry use counter; it saturates at all ones.
  localparam int COUNT_BITS = 16;

  // Width and reset value of the entries_in_use register.
  localparam int              LIMIT_BITS  = 5;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;

  typedef enum logic [0:0] {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

endpackage

// ----- hdl/lfu_cache_store_core.sv -----
// Fully associative LFU cache store with a least-recently-used tie-break.
//
//  channel   | signals                                    | transfer when
//  ----------+--------------------------------------------+------------------------------
//  request   | start, busy, operation_i, lookup_key_i,    | start high and busy low
//            | write_value_i                              |
//  result    | result_valid_o, hit_o, read_value_o,       | every cycle result_valid_o
//            | evicted_o                                  | is high (no back-pressure)
//  config    | cfg_valid_i, cfg_ready_o, cfg_data_i       | cfg_valid_i and cfg_ready_o
//
// Each access is captured in the request register; the tag match, the victim
// search and the state update then all complete at the edge that loads the
// result register. A new access may be issued in every cycle; it sees the
// state left by the previous one, since that state is written at the edge
// it is captured. Reset clears all valid marks, the occupancy count and the
// limit register (back to sixteen), so the store comes up empty and usable
// at once. busy never rises and the result side cannot stall, so nothing
// ever waits.
module lfu_cache_store_core #(
  parameter int CAPACITY   = lfu_pkg::DEF_CAPACITY,
  parameter int KEY_BITS   = lfu_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = lfu_pkg::DEF_VALUE_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Request channel.
  input  logic                           start,
  output logic                           busy,
  input  logic                           operation_i,
  input  logic [KEY_BITS-1:0]            lookup_key_i,
  input  logic [VALUE_BITS-1:0]          write_value_i,
  // Result strobe and payload.
  output logic                           result_valid_o,
  output logic                           hit_o,
  output logic [VALUE_BITS-1:0]          read_value_o,
  output logic                           evicted_o,
  // Configuration write channel for entries_in_use.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lfu_pkg::LIMIT_BITS-1:0] cfg_data_i
);

  // Slot index and recency rank share a width: ranks run 0 .. occupancy-1.
  localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEVELS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 0;
  localparam int LEAVES   = 1 << LEVELS;
  localparam int OCC_BITS = $clog2(CAPACITY + 1);
  localparam int CMP_BITS = (OCC_BITS > lfu_pkg::LIMIT_BITS) ? OCC_BITS : lfu_pkg::LIMIT_BITS;
  localparam int CNT_BITS = lfu_pkg::COUNT_BITS;

  localparam logic [CNT_BITS-1:0] COUNT_MAX = {CNT_BITS{1'b1}};

  // One candidate in the victim search tree.
  typedef struct packed {
    logic                ok;
    logic [CNT_BITS-1:0] count;
    logic [IDX_BITS-1:0] rank;
    logic [IDX_BITS-1:0] idx;
  } cand_t;

  // Request register.
  logic                  req_valid_q;
  lfu_pkg::op_e          req_op_q;
  logic [KEY_BITS-1:0]   req_key_q;
  logic [VALUE_BITS-1:0] req_val_q;

  // Configuration and occupancy.
  logic [lfu_pkg::LIMIT_BITS-1:0] limit_q;
  logic [OCC_BITS-1:0]            occ_q, occ_d;

  // Slot storage.
  logic [CAPACITY-1:0]   valid_q, valid_d;
  logic [KEY_BITS-1:0]   key_q   [CAPACITY];
  logic [KEY_BITS-1:0]   key_d   [CAPACITY];
  logic [VALUE_BITS-1:0] value_q [CAPACITY];
  logic [VALUE_BITS-1:0] value_d [CAPACITY];
  logic [CNT_BITS-1:0]   count_q [CAPACITY];
  logic [CNT_BITS-1:0]   count_d [CAPACITY];
  logic [IDX_BITS-1:0]   rank_q  [CAPACITY];
  logic [IDX_BITS-1:0]   rank_d  [CAPACITY];

  // Result register.
  logic                  res_valid_q;
  logic                  res_hit_q;
  logic [VALUE_BITS-1:0] res_value_q;
  logic                  res_evicted_q;

  // Lookup and decision signals.
  logic [CAPACITY-1:0]   hit_vec;
  logic                  any_hit;
  logic [VALUE_BITS-1:0] hit_value;
  logic [IDX_BITS-1:0]   hit_rank;
  cand_t                 node [2*LEAVES];
  logic [CAPACITY-1:0]   victim_oh;
  logic [CAPACITY-1:0]   free_vec;
  logic [CAPACITY-1:0]   target_oh;
  logic [CMP_BITS-1:0]   limit_eff;
  logic                  limit_nz;
  logic                  full;
  logic                  is_get;
  logic                  do_touch;
  logic                  do_write;
  logic                  do_insert;
  logic                  do_evict;
  logic                  inc_all;
  logic                  promote;
  logic [IDX_BITS-1:0]   promote_rank;

  // The store is single pass: it never pushes back on requests or config writes.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      limit_q     <= lfu_pkg::LIMIT_RESET;
      occ_q       <= '0;
      valid_q     <= '0;
    end else begin
      req_valid_q <= start && !busy;
      res_valid_q <= req_valid_q;
      occ_q       <= occ_d;
      valid_q     <= valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  // Payload registers carry no reset; invalid slots are never observed.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_op_q  <= lfu_pkg::op_e'(operation_i);
      req_key_q <= lookup_key_i;
      req_val_q <= write_value_i;
    end
    res_hit_q     <= any_hit;
    res_value_q   <= (is_get && any_hit) ? hit_value : '0;
    res_evicted_q <= do_evict;
    for (int i = 0; i < CAPACITY; i++) begin
      key_q[i]   <= key_d[i];
      value_q[i] <= value_d[i];
      count_q[i] <= count_d[i];
      rank_q[i]  <= rank_d[i];
    end
  end

  // Tag match. Valid keys are unique, so at most one slot can hit and the
  // read data and rank can be gathered with a plain AND-OR.
  always_comb begin
    hit_value = '0;
    hit_rank  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_vec[i] = valid_q[i] && (key_q[i] == req_key_q);
      hit_value  = hit_value | (value_q[i] & {VALUE_BITS{hit_vec[i]}});
      hit_rank   = hit_rank | (rank_q[i] & {IDX_BITS{hit_vec[i]}});
    end
    any_hit = |hit_vec;
  end

  // Victim search: a binary tree over all slots picks the valid entry with
  // the lowest use count, and among equal counts the oldest (highest rank).
  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      if (i < CAPACITY) begin
        node[LEAVES+i].ok    = valid_q[i];
        node[LEAVES+i].count = count_q[i];
        node[LEAVES+i].rank  = rank_q[i];
      end else begin
        node[LEAVES+i].ok    = 1'b0;
        node[LEAVES+i].count = '0;
        node[LEAVES+i].rank  = '0;
      end
      node[LEAVES+i].idx = IDX_BITS'(i);
    end
    for (int n = LEAVES - 1; n >= 1; n--) begin
      if (node[2*n+1].ok &&
          (!node[2*n].ok || (node[2*n+1].count < node[2*n].count) ||
           ((node[2*n+1].count == node[2*n].count) &&
            (node[2*n+1].rank > node[2*n].rank)))) begin
        node[n] = node[2*n+1];
      end else begin
        node[n] = node[2*n];
      end
    end
    node[0] = node[1];
  end

  // Decide what this access does.
  always_comb begin
    limit_eff = (CMP_BITS'(limit_q) > CMP_BITS'(CAPACITY)) ? CMP_BITS'(CAPACITY)
                                                          : CMP_BITS'(limit_q);
    limit_nz  = (limit_q != '0);
    full      = (CMP_BITS'(occ_q) >= limit_eff);
    is_get    = (req_op_q == lfu_pkg::OP_GET);
    do_touch  = req_valid_q && any_hit && (is_get || limit_nz);
    do_write  = req_valid_q && any_hit && !is_get && limit_nz;
    do_insert = req_valid_q && !any_hit && !is_get && limit_nz;
    do_evict  = do_insert && full && node[1].ok;
    inc_all   = do_insert && !do_evict;
    promote   = do_touch || do_evict;
    promote_rank = do_touch ? hit_rank : node[1].rank;
    for (int i = 0; i < CAPACITY; i++) begin
      victim_oh[i] = do_evict && (node[1].idx == IDX_BITS'(i));
    end
    // The new entry lands in the lowest free slot once the victim is gone.
    free_vec  = ~(valid_q & ~victim_oh);
    target_oh = free_vec & (~free_vec + CAPACITY'(1));
    occ_d     = inc_all ? occ_q + OCC_BITS'(1) : occ_q;
  end

  // Per-slot next state. Promoting with the threshold rank ages every entry
  // that was more recent than the touched or evicted one; a plain insert
  // ages every valid entry.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid_d[i] = (valid_q[i] && !victim_oh[i]) || (do_insert && target_oh[i]);
      key_d[i]   = key_q[i];
      value_d[i] = value_q[i];
      count_d[i] = count_q[i];
      rank_d[i]  = rank_q[i];
      if (do_insert && target_oh[i]) begin
        key_d[i]   = req_key_q;
        value_d[i] = req_val_q;
        count_d[i] = CNT_BITS'(1);
        rank_d[i]  = '0;
      end else if (do_touch && hit_vec[i]) begin
        if (do_write) begin
          value_d[i] = req_val_q;
        end
        if (count_q[i] != COUNT_MAX) begin
          count_d[i] = count_q[i] + CNT_BITS'(1);
        end
        rank_d[i] = '0;
      end else if (valid_q[i] && (inc_all || (promote && (rank_q[i] < promote_rank)))) begin
        rank_d[i] = rank_q[i] + IDX_BITS'(1);
      end
    end
  end

  assign result_valid_o = res_valid_q;
  assign hit_o          = res_hit_q;
  assign read_value_o   = res_value_q;
  assign evicted_o      = res_evicted_q;

endmodule

// ----- hdl/lfu_checker.sv -----
// Port-level checker for the LFU cache store, bound to its top level.
module lfu_checker #(
  parameter int KEY_BITS   = lfu_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = lfu_pkg::DEF_VALUE_BITS
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic                           operation_i,
  input logic [KEY_BITS-1:0]            lookup_key_i,
  input logic [VALUE_BITS-1:0]          write_value_i,
  input logic                           result_valid_o,
  input logic                           hit_o,
  input logic [VALUE_BITS-1:0]          read_value_o,
  input logic                           evicted_o,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic [lfu_pkg::LIMIT_BITS-1:0] cfg_data_i
);

  logic                           req_xfer;
  logic [lfu_pkg::LIMIT_BITS-1:0] limit_q;

  assign req_xfer = start && !busy;

  // Shadow copy of the limit register, to know when puts take effect.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= lfu_pkg::LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  // Every request transfer yields exactly one result, which passes through the
  // request register and then the result register.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer |-> ##2 result_valid_o)
    else $error("request transfer without a result two cycles later");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_xfer |-> ##2 !result_valid_o)
    else $error("result strobe without a request transfer");

  // An eviction only ever comes from a put that missed.
  a_evict_put_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && evicted_o) |->
      (!hit_o && ($past(operation_i, 2) == lfu_pkg::OP_PUT)))
    else $error("eviction reported for a hit or a get");

  // A put with inserts enabled followed at once by a get of the same key
  // must return the value just written. The limit that counts is the one
  // seen while the put is processed and held in the request register.
  a_put_then_get: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(req_xfer, 3) && $past(req_xfer, 2) &&
     ($past(operation_i, 3) == lfu_pkg::OP_PUT) &&
     ($past(operation_i, 2) == lfu_pkg::OP_GET) &&
     ($past(lookup_key_i, 3) == $past(lookup_key_i, 2)) &&
     ($past(limit_q, 2) != '0)) |->
      (hit_o && (read_value_o == $past(write_value_i, 3))))
    else $error("get right after a put did not return the written value");

endmodule

bind lfu_cache_store_core lfu_checker #(
  .KEY_BITS  (KEY_BITS),
  .VALUE_BITS(VALUE_BITS)
) u_lfu_checker (.*);
